### sv/mtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, codes and digit helpers shared by the MIDI time code decoder.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam logic OP_FULL    = 1'b0;
  localparam logic OP_QUARTER = 1'b1;

  localparam logic [2:0] PART_FRAME_LO = 3'd0;
  localparam logic [2:0] PART_HOUR_LO  = 3'd6;
  localparam logic [2:0] PART_HOUR_HI  = 3'd7;

  localparam int NUM_PARTS = 8;

  typedef struct packed {
    logic       op;
    logic [6:0] hour_byte;
    logic [6:0] minute_byte;
    logic [6:0] second_byte;
    logic [6:0] frame_byte;
    logic [6:0] quarter_byte;
  } mtc_in_t;

  typedef struct packed {
    logic [1:0] hours_tens;
    logic [3:0] hours_units;
    logic [4:0] minutes_tens;
    logic [3:0] minutes_units;
    logic [4:0] seconds_tens;
    logic [3:0] seconds_units;
    logic [4:0] frames_tens;
    logic [3:0] frames_units;
    logic [1:0] rate_type;
  } mtc_out_t;

  // divide by ten through multiply by 205 / 2048, exact for 0..255
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [4:0] q;
    logic [7:0] r;
    q = div10(v);
    r = v - ({3'd0, q} * 8'd10);
    return r[3:0];
  endfunction

endpackage

### sv/midi_timecode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_timecode_decoder
// Decodes MIDI time code full-frame and quarter-frame requests into digits.
// ----------------------------------------------------------------------------
// One request is taken per cycle while in_ready is high. A request is
// registered, then decoded and registered as a result once the output can
// advance. A full-frame request always yields a result; a quarter-frame
// request stores its nibble and yields a result only when the part sequence
// steps from 6 to 7 or from 7 to 0. While a result waits to be taken, a new
// request can enter only if the request register is empty.
module midi_timecode_decoder
  import mtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mtc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mtc_out_t out_data
);

  logic       req_valid_r;
  mtc_in_t    req_r;
  logic [3:0] nib_r   [NUM_PARTS];
  logic [3:0] nib_nxt [NUM_PARTS];
  logic [2:0] last_part_r;
  logic       out_valid_r;
  mtc_out_t   out_data_r;
  mtc_out_t   result;

  logic       advance;
  logic [2:0] part;
  logic [3:0] nib;
  logic       fire;
  logic       emit;
  logic [7:0] hours_v, minutes_v, seconds_v, frames_v;
  logic [1:0] rate_v;
  logic [4:0] hours_q;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign part = req_r.quarter_byte[6:4];
  assign nib  = req_r.quarter_byte[3:0];
  assign fire = (part == PART_HOUR_HI && last_part_r == PART_HOUR_LO) ||
                (part == PART_FRAME_LO && last_part_r == PART_HOUR_HI);
  assign emit = req_valid_r && advance && (req_r.op == OP_FULL || fire);

  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      nib_nxt[i] = nib_r[i];
    end
    if (req_r.op == OP_QUARTER) begin
      nib_nxt[part] = nib;
    end
    if (req_r.op == OP_FULL) begin
      hours_v   = {3'd0, req_r.hour_byte[4:0]};
      minutes_v = {1'b0, req_r.minute_byte};
      seconds_v = {1'b0, req_r.second_byte};
      frames_v  = {1'b0, req_r.frame_byte};
      rate_v    = req_r.hour_byte[6:5];
    end else begin
      hours_v   = {3'd0, nib_nxt[7][0], nib_nxt[6]};
      minutes_v = {nib_nxt[5], nib_nxt[4]};
      seconds_v = {nib_nxt[3], nib_nxt[2]};
      frames_v  = {nib_nxt[1], nib_nxt[0]};
      rate_v    = nib_nxt[7][2:1];
    end
    hours_q              = div10(hours_v);
    result.hours_tens    = hours_q[1:0];
    result.hours_units   = mod10(hours_v);
    result.minutes_tens  = div10(minutes_v);
    result.minutes_units = mod10(minutes_v);
    result.seconds_tens  = div10(seconds_v);
    result.seconds_units = mod10(seconds_v);
    result.frames_tens   = div10(frames_v);
    result.frames_units  = mod10(frames_v);
    result.rate_type     = rate_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      last_part_r <= '0;
      for (int i = 0; i < NUM_PARTS; i++) begin
        nib_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (req_valid_r && advance && req_r.op == OP_QUARTER) begin
        for (int i = 0; i < NUM_PARTS; i++) begin
          nib_r[i] <= nib_nxt[i];
        end
        last_part_r <= part;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (emit) begin
      out_data_r <= result;
    end
  end

endmodule

### sv/mtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_checker
// Port-level checks for the MIDI time code decoder, bound into midi_timecode_decoder.
// ----------------------------------------------------------------------------
module mtc_checker
  import mtc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input mtc_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input mtc_out_t out_data
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty output always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with empty output");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hours_units <= 4'd9 && out_data.minutes_units <= 4'd9 &&
                  out_data.seconds_units <= 4'd9 && out_data.frames_units <= 4'd9 &&
                  out_data.minutes_tens <= 5'd25 && out_data.seconds_tens <= 5'd25 &&
                  out_data.frames_tens <= 5'd25)
    else $error("digit out of range");

endmodule

bind midi_timecode_decoder mtc_checker u_mtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
